// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CHECK_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true outside reset
`define CHECK_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CHECK_PROP(label, clk, rstn, prop, msg)
`define CHECK_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

// File: rtl/core/trh_pkg.sv
// ----------------------------------------------------------------------------
// traffic rate history package
// item types, operation codes and the window status bundle
// ----------------------------------------------------------------------------
package trh_pkg;

    localparam int TOTAL_W        = 64;
    localparam int PORT_FIELD_W   = 3;
    localparam int BUCKET_FIELD_W = 4;
    localparam int TICKS_W        = 6;
    // widest bucket index, for a window of 64 buckets
    localparam int SLOT_MAX_W     = 6;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 6'd60;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                       operation;
        logic [PORT_FIELD_W-1:0]   port;
        logic [TOTAL_W-1:0]        rx_total;
        logic [TOTAL_W-1:0]        tx_total;
        logic                      counting_on;
        logic [BUCKET_FIELD_W-1:0] read_bucket;
    } in_item_t;

    typedef struct packed {
        logic [BUCKET_FIELD_W-1:0] current_bucket;
        logic [TOTAL_W-1:0]        rx_value;
        logic [TOTAL_W-1:0]        tx_value;
        logic                      shifted;
    } out_item_t;

    // time window status seen by the datapath
    typedef struct packed {
        logic [SLOT_MAX_W-1:0] active_bucket;
        logic [SLOT_MAX_W-1:0] ring_base;
        logic                  shifted;
    } win_state_t;

endpackage

// File: rtl/core/trh_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module trh_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/trh_window.sv
// ----------------------------------------------------------------------------
// time window control
// second and minute counters, window full flag and ring base of the buckets
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trh_window #(
    parameter int BUCKETS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [trh_pkg::TICKS_W-1:0]   cfg_wr_data,
    input  logic                          tick_en,
    output trh_pkg::win_state_t           win
);

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW:0]   MINUTE_WRAP = (BW+1)'(BUCKETS);
    localparam logic [BW-1:0] LAST_SLOT   = BW'(BUCKETS - 1);
    localparam logic [BW-1:0] ONE_SLOT    = BW'(1);

    logic [trh_pkg::TICKS_W-1:0] ticks_reg;
    logic [trh_pkg::TICKS_W-1:0] second_reg, second_next;
    logic [BW-1:0]               minute_reg, minute_next;
    logic [BW-1:0]               base_reg, base_next;
    logic [BW-1:0]               active_reg, active_next;
    logic                        full_reg, full_next;
    logic                        shifted_reg, shifted_next;

    // tick handling: roll seconds into minutes, shift the ring once full
    always_comb begin
        second_next  = second_reg;
        minute_next  = minute_reg;
        base_next    = base_reg;
        active_next  = active_reg;
        full_next    = full_reg;
        shifted_next = shifted_reg;
        if (tick_en) begin
            shifted_next = 1'b0;
            if (({1'b0, second_reg} + 7'd1) >= {1'b0, ticks_reg}) begin
                second_next = '0;
                if (({1'b0, minute_reg} + {{BW{1'b0}}, 1'b1}) >= MINUTE_WRAP) begin
                    minute_next = '0;
                    full_next   = 1'b1;
                end else begin
                    minute_next = minute_reg + ONE_SLOT;
                end
                if (full_next) begin
                    shifted_next = 1'b1;
                    base_next    = (base_reg == LAST_SLOT) ? '0 : base_reg + ONE_SLOT;
                end
            end else begin
                second_next = second_reg + 6'd1;
            end
            active_next = full_next ? LAST_SLOT : minute_next;
        end
    end

    // counters and configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg   <= trh_pkg::TICKS_RESET;
            second_reg  <= '0;
            minute_reg  <= '0;
            base_reg    <= '0;
            active_reg  <= '0;
            full_reg    <= 1'b0;
            shifted_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ticks_reg <= cfg_wr_data;
            end
            second_reg  <= second_next;
            minute_reg  <= minute_next;
            base_reg    <= base_next;
            active_reg  <= active_next;
            full_reg    <= full_next;
            shifted_reg <= shifted_next;
        end
    end

    assign win.active_bucket = trh_pkg::SLOT_MAX_W'(active_reg);
    assign win.ring_base     = trh_pkg::SLOT_MAX_W'(base_reg);
    assign win.shifted       = shifted_reg;

    `CHECK_PROP(a_base_in_range, aclk, aresetn, {1'b0, base_reg} < MINUTE_WRAP, "ring base beyond window")
    `CHECK_PROP(a_shift_needs_full, aclk, aresetn, shifted_reg |-> full_reg, "shift before window full")
    `CHECK_PROP(a_full_uses_top, aclk, aresetn, full_reg |-> active_reg == LAST_SLOT, "full window not on top bucket")

endmodule

// File: rtl/core/traffic_rate_history.sv
// ----------------------------------------------------------------------------
// traffic rate history
// per-port rx and tx byte history in per-minute buckets
// ----------------------------------------------------------------------------
// Items are taken one at a time, the next only after the last write-back:
// the read step reads the port's history bucket and its baselines from two
// single-read-port memories, the write-back step adds the byte deltas, writes
// both memories back and loads the result register. The history is kept as
// a ring per port, so a minute shift only moves the ring base and drops the
// valid flags of one column of entries. Reset clears all valid flags at once,
// so there is no clearing pass after reset. A result waiting in the output register
// does not stop the next item from being read; it only holds the write-back stage.
`include "assert_macros.svh"

module traffic_rate_history #(
    parameter int BUCKETS    = 16,
    parameter int PORT_COUNT = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [trh_pkg::TICKS_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  trh_pkg::in_item_t           s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output trh_pkg::out_item_t          m_item
);

    localparam int BW         = $clog2(BUCKETS);
    localparam int PW         = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int HIST_AW    = PW + BW;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int PORT_SLOTS = 1 << PW;
    localparam int TW         = trh_pkg::TOTAL_W;
    localparam logic [BW:0]   SLOT_WRAP = (BW+1)'(BUCKETS);
    localparam logic [BW-1:0] LAST_SLOT = BW'(BUCKETS - 1);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                state_reg;
    logic                  m_valid_reg;
    trh_pkg::out_item_t    m_item_reg, result;
    trh_pkg::win_state_t   win;
    trh_pkg::in_item_t     item_reg;

    logic                  accept, fire, out_free;
    logic                  port_ok, rb_ok, port_ok_reg, rb_ok_reg;
    logic [BW-1:0]         base_slot, logical_sel, clear_slot;
    logic [HIST_AW-1:0]    rd_addr, addr_reg;
    logic [PW-1:0]         port_idx;
    logic [HIST_DEPTH-1:0] hist_valid_reg, col_mask;
    logic [PORT_SLOTS-1:0] base_valid_reg;

    logic                  hist_wr_en, base_wr_en, clear_col;
    logic [2*TW-1:0]       hist_rd_data, base_rd_data, hist_wr_data;
    logic [TW-1:0]         hist_rx, hist_tx, upd_rx, upd_tx;
    logic                  do_sample, do_count;

    // logical bucket to physical ring slot
    function automatic logic [BW-1:0] to_slot(input logic [BW-1:0] logical,
                                              input logic [BW-1:0] base);
        logic [BW:0] sum;
        sum = {1'b0, logical} + {1'b0, base};
        if (sum >= SLOT_WRAP) begin
            sum = sum - SLOT_WRAP;
        end
        return sum[BW-1:0];
    endfunction

    // read stage: address the port's bucket on accept
    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign port_ok     = (32'(s_item.port) < 32'(PORT_COUNT));
    assign rb_ok       = (32'(s_item.read_bucket) < 32'(BUCKETS));
    assign base_slot   = win.ring_base[BW-1:0];
    assign logical_sel = (s_item.operation == trh_pkg::OP_READ) ?
                         BW'(s_item.read_bucket) : win.active_bucket[BW-1:0];
    assign rd_addr     = {PW'(s_item.port), to_slot(logical_sel, base_slot)};

    // item held for the write-back stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg    <= s_item;
            addr_reg    <= rd_addr;
            port_ok_reg <= port_ok;
            rb_ok_reg   <= rb_ok;
        end
    end

    trh_window #(
        .BUCKETS (BUCKETS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick_en     (accept && (s_item.operation == trh_pkg::OP_TICK)),
        .win         (win)
    );

    trh_ram #(
        .WIDTH (2*TW),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_wr_en),
        .wr_addr (addr_reg),
        .wr_data (hist_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (hist_rd_data)
    );

    trh_ram #(
        .WIDTH (2*TW),
        .DEPTH (PORT_SLOTS)
    ) u_base_ram (
        .aclk    (aclk),
        .wr_en   (base_wr_en),
        .wr_addr (port_idx),
        .wr_data ({item_reg.rx_total, item_reg.tx_total}),
        .rd_en   (accept),
        .rd_addr (PW'(s_item.port)),
        .rd_data (base_rd_data)
    );

    // write-back stage: add deltas to the bucket, move the baselines
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = (state_reg == S_EXEC) && out_free;
    assign port_idx  = addr_reg[HIST_AW-1:BW];
    assign hist_rx   = hist_valid_reg[addr_reg] ? hist_rd_data[2*TW-1:TW] : '0;
    assign hist_tx   = hist_valid_reg[addr_reg] ? hist_rd_data[TW-1:0] : '0;
    assign upd_rx    = base_valid_reg[port_idx] ?
                       hist_rx + (item_reg.rx_total - base_rd_data[2*TW-1:TW]) : hist_rx;
    assign upd_tx    = base_valid_reg[port_idx] ?
                       hist_tx + (item_reg.tx_total - base_rd_data[TW-1:0]) : hist_tx;
    assign do_sample = (item_reg.operation == trh_pkg::OP_SAMPLE) && port_ok_reg;
    assign do_count  = do_sample && item_reg.counting_on;
    assign hist_wr_en   = fire && do_count;
    assign base_wr_en   = fire && do_count;
    assign hist_wr_data = {upd_rx, upd_tx};

    // a shift frees the column that becomes the new top bucket
    assign clear_col  = fire && (item_reg.operation == trh_pkg::OP_TICK) && win.shifted;
    assign clear_slot = to_slot(LAST_SLOT, base_slot);
    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            col_mask[i] = (BW'(i) == clear_slot);
        end
    end

    // valid flags for history entries and port baselines
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg <= '0;
            base_valid_reg <= '0;
        end else begin
            if (clear_col) begin
                hist_valid_reg <= hist_valid_reg & ~col_mask;
            end
            if (hist_wr_en) begin
                hist_valid_reg[addr_reg] <= 1'b1;
            end
            if (fire && do_sample) begin
                base_valid_reg[port_idx] <= item_reg.counting_on;
            end
        end
    end

    // result of the item
    always_comb begin
        result                = '0;
        result.current_bucket = trh_pkg::BUCKET_FIELD_W'(win.active_bucket);
        case (item_reg.operation)
            trh_pkg::OP_SAMPLE: begin
                if (do_count) begin
                    result.rx_value = upd_rx;
                    result.tx_value = upd_tx;
                end else if (do_sample) begin
                    result.rx_value = hist_rx;
                    result.tx_value = hist_tx;
                end
            end
            trh_pkg::OP_READ: begin
                if (port_ok_reg && rb_ok_reg) begin
                    result.rx_value = hist_rx;
                    result.tx_value = hist_tx;
                end
            end
            trh_pkg::OP_TICK: begin
                result.shifted = win.shifted;
            end
            default: begin
                result.shifted = 1'b0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_item_reg  <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `CHECK_PROP(a_accept_to_exec, aclk, aresetn, accept |=> state_reg == S_EXEC, "accepted item not executed")
    `CHECK_PROP(a_result_from_exec, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == S_EXEC), "result without item")
    `CHECK_NEVER(a_wb_bad_port, aclk, aresetn, hist_wr_en && !port_ok_reg, "history write for absent port")

endmodule

// File: dv/traffic_rate_history_tb.sv
// ----------------------------------------------------------------------------
// traffic rate history testbench
// drives sample, tick, read and idle items through the block under several
// bucket lengths and idling patterns, predicts every result from its own
// copy of the per-port history and compares each returned item field by field
// ----------------------------------------------------------------------------
module traffic_rate_history_tb;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 340;
    localparam int PHASES           = 4;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 250;
    localparam int STALL_LIMIT      = 4000;
    localparam int REPORT_LIMIT     = 10;
    localparam int NUM_PORTS        = 8;

    typedef enum int {IDLE_SPLIT, IDLE_SWAPPED, IDLE_NONE} idle_mode_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [trh_pkg::TICKS_W-1:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    trh_pkg::in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    trh_pkg::out_item_t m_item;

    idle_mode_t idle_mode;
    bit         hold_request;
    int         stall_cycles;
    logic [trh_pkg::TOTAL_W-1:0] run_rx [NUM_PORTS];
    logic [trh_pkg::TOTAL_W-1:0] run_tx [NUM_PORTS];

    // per-port history predictor and store of expected result items
    class rate_history_board;
        localparam int NUM_BUCKETS = 16;
        localparam int PORTS       = 8;

        logic [trh_pkg::TOTAL_W-1:0] rx_hist [PORTS][NUM_BUCKETS];
        logic [trh_pkg::TOTAL_W-1:0] tx_hist [PORTS][NUM_BUCKETS];
        logic [trh_pkg::TOTAL_W-1:0] rx_base [PORTS];
        logic [trh_pkg::TOTAL_W-1:0] tx_base [PORTS];
        logic [1:0]         base_valid [PORTS];
        int unsigned        sec_count;
        int unsigned        min_count;
        bit                 window_full;
        logic [trh_pkg::BUCKET_FIELD_W-1:0] active;
        logic [trh_pkg::TICKS_W-1:0] ticks;
        trh_pkg::out_item_t awaited_q[$];
        int                 failures;

        function new();
            for (int p = 0; p < PORTS; p++) begin
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    rx_hist[p][b] = '0;
                    tx_hist[p][b] = '0;
                end
                rx_base[p]    = '0;
                tx_base[p]    = '0;
                base_valid[p] = 2'b00;
            end
            sec_count   = 0;
            min_count   = 0;
            window_full = 1'b0;
            active      = '0;
            ticks       = trh_pkg::TICKS_RESET;
            failures    = 0;
        endfunction

        function void write_ticks(logic [trh_pkg::TICKS_W-1:0] value);
            ticks = value;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // work out the result of one accepted item and queue it
        function void note_input(trh_pkg::in_item_t it);
            trh_pkg::out_item_t res;
            int unsigned p;
            res = '0;
            p = 32'(it.port);
            case (it.operation)
                trh_pkg::OP_SAMPLE: begin
                    if (!it.counting_on) begin
                        base_valid[p] = 2'b00;
                    end else begin
                        if (base_valid[p][0])
                            rx_hist[p][active] = rx_hist[p][active] + (it.rx_total - rx_base[p]);
                        else
                            base_valid[p][0] = 1'b1;
                        rx_base[p] = it.rx_total;
                        if (base_valid[p][1])
                            tx_hist[p][active] = tx_hist[p][active] + (it.tx_total - tx_base[p]);
                        else
                            base_valid[p][1] = 1'b1;
                        tx_base[p] = it.tx_total;
                    end
                    res.rx_value = rx_hist[p][active];
                    res.tx_value = tx_hist[p][active];
                end
                trh_pkg::OP_TICK: begin
                    // a register value of zero rolls over on every tick
                    if (sec_count + 1 >= ticks) begin
                        sec_count = 0;
                        min_count++;
                        if (min_count >= NUM_BUCKETS) begin
                            min_count   = 0;
                            window_full = 1'b1;
                        end
                        if (window_full) begin
                            for (int q = 0; q < PORTS; q++) begin
                                for (int b = 0; b + 1 < NUM_BUCKETS; b++) begin
                                    rx_hist[q][b] = rx_hist[q][b+1];
                                    tx_hist[q][b] = tx_hist[q][b+1];
                                end
                                rx_hist[q][NUM_BUCKETS-1] = '0;
                                tx_hist[q][NUM_BUCKETS-1] = '0;
                            end
                            res.shifted = 1'b1;
                        end
                    end else begin
                        sec_count++;
                    end
                    active = window_full ? trh_pkg::BUCKET_FIELD_W'(NUM_BUCKETS - 1) :
                                           trh_pkg::BUCKET_FIELD_W'(min_count);
                end
                trh_pkg::OP_READ: begin
                    res.rx_value = rx_hist[p][it.read_bucket];
                    res.tx_value = tx_hist[p][it.read_bucket];
                end
                default: ;
            endcase
            res.current_bucket = active;
            awaited_q.push_back(res);
        endfunction

        // compare one returned item with the oldest expectation
        function void check_result(trh_pkg::out_item_t got);
            trh_pkg::out_item_t want;
            if (awaited_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result item: bucket %0d rx %h tx %h shifted %b",
                             got.current_bucket, got.rx_value, got.tx_value, got.shifted);
                return;
            end
            want = awaited_q.pop_front();
            if (got.current_bucket !== want.current_bucket || got.rx_value !== want.rx_value ||
                got.tx_value !== want.tx_value || got.shifted !== want.shifted) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result mismatch: expected bucket %0d rx %h tx %h shifted %b",
                             want.current_bucket, want.rx_value, want.tx_value, want.shifted);
                    $display("                 actual   bucket %0d rx %h tx %h shifted %b",
                             got.current_bucket, got.rx_value, got.tx_value, got.shifted);
                end
            end
        endfunction
    endclass

    rate_history_board board;

    traffic_rate_history DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int sender_pct();
        case (idle_mode)
            IDLE_SPLIT:   return 38;
            IDLE_SWAPPED: return 46;
            default:      return 0;
        endcase
    endfunction

    function automatic int receiver_pct();
        case (idle_mode)
            IDLE_SPLIT:   return 46;
            IDLE_SWAPPED: return 38;
            default:      return 0;
        endcase
    endfunction

    // handshake monitor, predictor feed and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                board.write_ticks(cfg_wr_data);
            if (s_valid && s_ready)
                board.note_input(s_item);
            if (m_valid && m_ready)
                board.check_result(m_item);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_pct());
            end
        end
    end

    // offer one item, with random gaps before it, and wait for acceptance
    task automatic send_item(input trh_pkg::in_item_t it);
        while ($urandom_range(0, 99) < sender_pct()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_fields(input trh_pkg::op_t op, input int unsigned port,
                               input logic [trh_pkg::TOTAL_W-1:0] rx,
                               input logic [trh_pkg::TOTAL_W-1:0] tx,
                               input logic on, input int unsigned bucket);
        trh_pkg::in_item_t it;
        it.operation   = op;
        it.port        = trh_pkg::PORT_FIELD_W'(port);
        it.rx_total    = rx;
        it.tx_total    = tx;
        it.counting_on = on;
        it.read_bucket = trh_pkg::BUCKET_FIELD_W'(bucket);
        send_item(it);
    endtask

    // stop offering and let every expected result come back
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_ticks_reg(input logic [trh_pkg::TICKS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // byte increment: mostly small, sometimes large enough to wrap the total
    function automatic logic [trh_pkg::TOTAL_W-1:0] byte_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return trh_pkg::TOTAL_W'($urandom_range(0, 5000));
        else if (pick < 95)
            return {32'd0, $urandom};
        else
            return {$urandom, $urandom};
    endfunction

    // mostly well-formed running totals per port, some counting-off and noise
    function automatic trh_pkg::in_item_t next_random_item();
        trh_pkg::in_item_t it;
        int unsigned pick;
        int unsigned p;
        it.operation   = trh_pkg::OP_NOP;
        it.port        = trh_pkg::PORT_FIELD_W'($urandom_range(0, NUM_PORTS - 1));
        it.rx_total    = {$urandom, $urandom};
        it.tx_total    = {$urandom, $urandom};
        it.counting_on = 1'($urandom_range(0, 1));
        it.read_bucket = trh_pkg::BUCKET_FIELD_W'($urandom_range(0, 15));
        p    = 32'(it.port);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.operation = trh_pkg::OP_SAMPLE;
            if (pick < 52) begin
                it.rx_total    = run_rx[p] + byte_step();
                it.tx_total    = run_tx[p] + byte_step();
                it.counting_on = (pick >= 50) ? 1'b0 : 1'b1;
            end
            run_rx[p] = it.rx_total;
            run_tx[p] = it.tx_total;
        end else if (pick < 75) begin
            it.operation = trh_pkg::OP_TICK;
        end else if (pick < 95) begin
            it.operation = trh_pkg::OP_READ;
        end
        return it;
    endfunction

    // main sequence
    initial begin : stimulus
        logic [trh_pkg::TICKS_W-1:0] phase_ticks [PHASES];
        idle_mode_t                  phase_idle  [PHASES];
        logic [trh_pkg::TOTAL_W-1:0] ones;
        phase_ticks = '{6'd3, 6'd63, 6'd0, 6'd1};
        phase_idle  = '{IDLE_SPLIT, IDLE_SWAPPED, IDLE_NONE, IDLE_NONE};
        ones = '1;
        board        = new();
        idle_mode    = IDLE_SPLIT;
        hold_request = 1'b0;
        stall_cycles = 0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_item       = '0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            run_rx[p] = '0;
            run_tx[p] = '0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty history, unused code, baseline, full-range wrap
        send_fields(trh_pkg::OP_READ,   0, '0,   '0,   1'b1, 0);
        send_fields(trh_pkg::OP_NOP,    7, ones, ones, 1'b1, 15);
        send_fields(trh_pkg::OP_SAMPLE, 0, '0,   '0,   1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 0, ones, ones, 1'b1, 15);
        send_fields(trh_pkg::OP_SAMPLE, 0, '0,   '0,   1'b1, 0);
        // counting off clears the baselines, next sample only rebases
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h1000, 64'h2000, 1'b0, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h1000, 64'h2000, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h1005, 64'h2009, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h1010, 64'h2010, 1'b0, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h9000, 64'h9000, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h9001, 64'h9003, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 3, 64'hffff_ffff_ffff_fff0,
                    64'h8000_0000_0000_0000, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 3, 64'h0000_0000_0000_000f,
                    64'h7fff_ffff_ffff_ffff, 1'b1, 0);
        send_fields(trh_pkg::OP_TICK,   5, ones, '0,   1'b0, 15);
        send_fields(trh_pkg::OP_READ,   7, '0,   '0,   1'b0, 0);
        send_fields(trh_pkg::OP_READ,   3, '0,   '0,   1'b1, 0);
        send_fields(trh_pkg::OP_READ,   7, ones, ones, 1'b1, 15);
        send_fields(trh_pkg::OP_TICK,   0, '0,   ones, 1'b1, 0);
        send_fields(trh_pkg::OP_SAMPLE, 7, 64'h9101, 64'h9103, 1'b1, 0);
        send_fields(trh_pkg::OP_NOP,    0, '0,   '0,   1'b0, 0);
        run_rx[0] = '0;
        run_tx[0] = '0;
        run_rx[3] = 64'h0000_0000_0000_000f;
        run_tx[3] = 64'h7fff_ffff_ffff_ffff;
        run_rx[7] = 64'h9101;
        run_tx[7] = 64'h9103;

        // random phases, each with its own bucket length and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_ticks_reg(phase_ticks[ph]);
            idle_mode = phase_idle[ph];
            if (ph == 2)
                hold_request = 1'b1;
            repeat (RANDOM_PER_PHASE) send_item(next_random_item());
        end

        drain();
        if (board.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/trh_pkg.sv
rtl/core/trh_ram.sv
rtl/core/trh_window.sv
rtl/core/traffic_rate_history.sv
dv/traffic_rate_history_tb.sv
